FILE: src/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent on a clock edge implies the consequent property
`define DPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never be seen on a clock edge out of reset
`define DPA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

FILE: src/dpa_pkg.sv
// types, widths, constants and helper functions of the point acceptance unit
package dpa_pkg;

	localparam int LAV_STATIONS    = 12;
	localparam int STRAW_CHAMBERS  = 4;
	localparam int COORD_FRAC_BITS = 6;

	localparam int POS_W   = 20;
	localparam int DET_W   = 4;
	localparam int ST_W    = 4;
	localparam int LIMIT_W = 19;

	// coordinate times ten
	localparam int X_W   = POS_W + 4;
	// largest x offset is below 2^11 tenths of a mm
	localparam int OFF_W = 11 + COORD_FRAC_BITS;
	localparam int XC_W  = ((OFF_W > X_W) ? OFF_W : X_W) + 1;
	localparam int D_W   = XC_W + 1;
	// largest default limit is below 2^14 tenths of a mm
	localparam int LIM_W = ((14 + COORD_FRAC_BITS) > (LIMIT_W + 4)) ?
		(14 + COORD_FRAC_BITS) : (LIMIT_W + 4);
	localparam int CMP_W = ((XC_W > LIM_W) ? XC_W : LIM_W) + 1;
	localparam int PD_W  = 2 * D_W;
	localparam int PL_W  = 2 * LIM_W;
	localparam int SQ_W  = ((PD_W > PL_W) ? PD_W : PL_W) + 2;

	// start beat to result strobe
	localparam int LATENCY = 6;

	typedef enum logic [DET_W-1:0] {
		DET_STRAW   = 4'd0,
		DET_RICH    = 4'd1,
		DET_CHOD    = 4'd2,
		DET_NEWCHOD = 4'd3,
		DET_LAV     = 4'd4,
		DET_IRC     = 4'd5,
		DET_LKR     = 4'd6,
		DET_MUV1    = 4'd7,
		DET_MUV2    = 4'd8,
		DET_MUV3    = 4'd9,
		DET_SAC     = 4'd10,
		DET_OTHER   = 4'd11
	} det_t;

	// straw beam hole half-side, 638 tenths of a mm in the scaled coordinate format
	localparam longint unsigned HOLE_L = longint'(638) << COORD_FRAC_BITS;
	localparam logic [SQ_W-1:0] HOLE_SQ_X2 = SQ_W'(2 * HOLE_L * HOLE_L);

	typedef struct packed {
		logic ax_lt_ro;
		logic ay_lt_ro;
		logic ax_lt_ro_wide;
		logic ay_gt_hole;
		logic ax_lt_r1;
		logic ay_lt_r1;
	} lin_flags_t;

	// tenths of a mm into the scaled coordinate format
	function automatic logic [LIM_W-1:0] tenths(input logic [13:0] t);
		return LIM_W'(t) << COORD_FRAC_BITS;
	endfunction

	function automatic logic [LIM_W-1:0] straw_centre(input logic [2:0] idx);
		logic [13:0] t;
		case (idx)
			3'd0:    t = 14'd1012;
			3'd1:    t = 14'd1144;
			3'd2:    t = 14'd924;
			default: t = 14'd528;
		endcase
		return tenths(t);
	endfunction

	function automatic logic [LIM_W-1:0] lav_radius(input logic [ST_W-1:0] idx);
		logic [13:0] t;
		case (idx) inside
			[4'd0:4'd4]:  t = 14'd5365;
			[4'd5:4'd7]:  t = 14'd7675;
			[4'd8:4'd10]: t = 14'd9800;
			default:      t = 14'd10700;
		endcase
		return tenths(t);
	endfunction

	// user value times ten, or the default when the user value is zero
	function automatic logic [LIM_W-1:0] pick(input logic [LIMIT_W-1:0] u,
		input logic [LIM_W-1:0] dflt);
		logic [LIM_W-1:0] ue;
		ue = LIM_W'(u);
		if (u != '0) begin
			return (ue << 3) + (ue << 1);
		end
		return dflt;
	endfunction

	function automatic logic [PD_W-1:0] sq_s(input logic signed [D_W-1:0] v);
		logic signed [PD_W-1:0] p;
		p = v * v;
		return $unsigned(p);
	endfunction

	function automatic logic [PL_W-1:0] sq_u(input logic [LIM_W-1:0] v);
		logic [PL_W-1:0] p;
		p = v * v;
		return p;
	endfunction

endpackage

FILE: src/detector_point_acceptance_unit.sv
// top level of the detector point acceptance unit
//
// Checks one hit point per clock against the acceptance shape of the chosen
// detector. A beat is taken on every edge with start high and busy low; busy
// is always low, so a new point may be given on every cycle. The verdict
// appears on accepted and bad_station, marked by a one-cycle done strobe,
// in the order the points went in. Each point passes six register stages:
// limit selection, offset and magnitudes, linear compares, squaring,
// squared compares, final verdict. The receiver cannot hold results off, so
// there is nothing to stall.
module detector_point_acceptance_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [dpa_pkg::POS_W-1:0]         pos_x,
	input  logic signed [dpa_pkg::POS_W-1:0]         pos_y,
	input  logic        [dpa_pkg::DET_W-1:0]         detector_code,
	input  logic        [dpa_pkg::ST_W-1:0]          station_number,
	input  logic        [dpa_pkg::LIMIT_W-1:0]       inner_limit,
	input  logic        [dpa_pkg::LIMIT_W-1:0]       outer_limit,
	output logic                                     done,
	output logic                                     accepted,
	output logic                                     bad_station
);

	localparam int X_W   = dpa_pkg::X_W;
	localparam int OFF_W = dpa_pkg::OFF_W;
	localparam int XC_W  = dpa_pkg::XC_W;
	localparam int D_W   = dpa_pkg::D_W;
	localparam int LIM_W = dpa_pkg::LIM_W;
	localparam int CMP_W = dpa_pkg::CMP_W;
	localparam int PD_W  = dpa_pkg::PD_W;
	localparam int PL_W  = dpa_pkg::PL_W;
	localparam int SQ_W  = dpa_pkg::SQ_W;

	// a pure feed-forward pipeline never refuses a beat
	assign busy = 1'b0;

	// ---------------- stage 1: scale, station check, limit selection
	logic                      take;
	logic signed [X_W-1:0]     px_ext, py_ext;
	logic                      bad_c;
	logic        [LIM_W-1:0]   r1_dflt, ro_dflt;
	logic        [OFF_W-1:0]   off_c;
	dpa_pkg::det_t             det_in;

	assign take   = start && !busy;
	assign px_ext = X_W'(pos_x);
	assign py_ext = X_W'(pos_y);
	assign det_in = dpa_pkg::det_t'(detector_code);

	// straw and lav stations beyond the built range reject the point
	always_comb begin
		bad_c = 1'b0;
		if (det_in == dpa_pkg::DET_STRAW &&
			(5'(station_number) >= 5'(dpa_pkg::STRAW_CHAMBERS))) begin
			bad_c = 1'b1;
		end
		if (det_in == dpa_pkg::DET_LAV &&
			(5'(station_number) >= 5'(dpa_pkg::LAV_STATIONS))) begin
			bad_c = 1'b1;
		end
	end

	// built-in limits and the x shift of the shape centre, per detector
	always_comb begin
		r1_dflt = '0;
		ro_dflt = '0;
		off_c   = '0;
		case (det_in)
			dpa_pkg::DET_STRAW: begin
				r1_dflt = dpa_pkg::tenths(14'd638);
				ro_dflt = dpa_pkg::tenths(14'd10000);
				off_c   = OFF_W'(dpa_pkg::straw_centre(station_number[2:0]));
			end
			dpa_pkg::DET_RICH: begin
				r1_dflt = dpa_pkg::tenths(14'd1000);
				off_c   = OFF_W'(dpa_pkg::tenths(14'd340));
			end
			dpa_pkg::DET_CHOD: begin
				r1_dflt = dpa_pkg::tenths(14'd1300);
				ro_dflt = dpa_pkg::tenths(14'd11000);
			end
			dpa_pkg::DET_NEWCHOD: begin
				r1_dflt = dpa_pkg::tenths(14'd1400);
				ro_dflt = dpa_pkg::tenths(14'd10700);
			end
			dpa_pkg::DET_LAV: begin
				ro_dflt = dpa_pkg::lav_radius(station_number);
			end
			dpa_pkg::DET_IRC: begin
				r1_dflt = dpa_pkg::tenths(14'd600);
				ro_dflt = dpa_pkg::tenths(14'd1450);
			end
			dpa_pkg::DET_LKR: begin
				r1_dflt = dpa_pkg::tenths(14'd1500);
				ro_dflt = dpa_pkg::tenths(14'd11300);
			end
			dpa_pkg::DET_MUV1, dpa_pkg::DET_MUV2: begin
				r1_dflt = dpa_pkg::tenths(14'd1300);
				ro_dflt = dpa_pkg::tenths(14'd11000);
			end
			dpa_pkg::DET_MUV3: begin
				r1_dflt = dpa_pkg::tenths(14'd1030);
				ro_dflt = dpa_pkg::tenths(14'd13200);
			end
			dpa_pkg::DET_SAC: begin
				// inner limit is the half-side of the square
				r1_dflt = dpa_pkg::tenths(14'd1000);
			end
			default: begin
				r1_dflt = '0;
			end
		endcase
	end

	logic                      v_s1;
	dpa_pkg::det_t             det_s1;
	logic                      bad_s1;
	logic signed [X_W-1:0]     x_s1, y_s1;
	logic        [OFF_W-1:0]   off_s1;
	logic        [LIM_W-1:0]   r1_s1, ro_s1;

	always_ff @(posedge clk) begin
		det_s1 <= det_in;
		bad_s1 <= bad_c;
		// times ten as two shifted copies
		x_s1   <= (px_ext <<< 3) + (px_ext <<< 1);
		y_s1   <= (py_ext <<< 3) + (py_ext <<< 1);
		off_s1 <= off_c;
		r1_s1  <= dpa_pkg::pick(inner_limit, r1_dflt);
		ro_s1  <= dpa_pkg::pick(outer_limit, ro_dflt);
	end

	// ---------------- stage 2: shifted x and magnitudes
	logic                      v_s2;
	dpa_pkg::det_t             det_s2;
	logic                      bad_s2;
	logic signed [XC_W-1:0]    xc_s2, y_s2;
	logic        [XC_W-1:0]    ax_s2, ay_s2;
	logic        [LIM_W-1:0]   r1_s2, ro_s2;

	always_ff @(posedge clk) begin
		det_s2 <= det_s1;
		bad_s2 <= bad_s1;
		xc_s2  <= XC_W'(x_s1) - XC_W'($signed({1'b0, off_s1}));
		y_s2   <= XC_W'(y_s1);
		ax_s2  <= x_s1[X_W-1] ? XC_W'(-x_s1) : XC_W'(x_s1);
		ay_s2  <= y_s1[X_W-1] ? XC_W'(-y_s1) : XC_W'(y_s1);
		r1_s2  <= r1_s1;
		ro_s2  <= ro_s1;
	end

	// ---------------- stage 3: rotated view, box compares
	localparam logic [LIM_W-1:0] HOLE  = dpa_pkg::tenths(14'd638);
	localparam logic [LIM_W-1:0] WIDEN = dpa_pkg::tenths(14'd4);

	logic                      v_s3;
	dpa_pkg::det_t             det_s3;
	logic                      bad_s3;
	logic signed [D_W-1:0]     d_s3, s_s3, sum_s3;
	logic        [XC_W-1:0]    axc_s3, ax_s3, ay_s3;
	logic        [LIM_W-1:0]   r1_s3, ro_s3;
	dpa_pkg::lin_flags_t       lf_c, lf_s3;

	always_comb begin
		lf_c.ax_lt_ro      = CMP_W'(ax_s2) < CMP_W'(ro_s2);
		lf_c.ay_lt_ro      = CMP_W'(ay_s2) < CMP_W'(ro_s2);
		// muv3 x half-side widened by half the central gap
		lf_c.ax_lt_ro_wide = CMP_W'(ax_s2) < (CMP_W'(ro_s2) + CMP_W'(WIDEN));
		lf_c.ay_gt_hole    = CMP_W'(ay_s2) > CMP_W'(HOLE);
		lf_c.ax_lt_r1      = CMP_W'(ax_s2) < CMP_W'(r1_s2);
		lf_c.ay_lt_r1      = CMP_W'(ay_s2) < CMP_W'(r1_s2);
	end

	always_ff @(posedge clk) begin
		det_s3 <= det_s2;
		bad_s3 <= bad_s2;
		d_s3   <= D_W'(xc_s2) - D_W'(y_s2);
		s_s3   <= D_W'(xc_s2) + D_W'(y_s2);
		sum_s3 <= $signed(D_W'(ax_s2) + D_W'(ay_s2));
		axc_s3 <= xc_s2[XC_W-1] ? XC_W'(-xc_s2) : XC_W'(xc_s2);
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
		r1_s3  <= r1_s2;
		ro_s3  <= ro_s2;
		lf_s3  <= lf_c;
	end

	// ---------------- stage 4: squares
	logic                      v_s4;
	dpa_pkg::det_t             det_s4;
	logic                      bad_s4;
	logic        [PD_W-1:0]    xc2_s4, x2_s4, y2_s4, d2_s4, s2_s4, sum2_s4;
	logic        [PL_W-1:0]    r12_s4, ro2_s4;
	logic                      axc_gt_hole_s4;
	dpa_pkg::lin_flags_t       lf_s4;

	always_ff @(posedge clk) begin
		det_s4         <= det_s3;
		bad_s4         <= bad_s3;
		xc2_s4         <= dpa_pkg::sq_s($signed({1'b0, axc_s3}));
		x2_s4          <= dpa_pkg::sq_s($signed({1'b0, ax_s3}));
		y2_s4          <= dpa_pkg::sq_s($signed({1'b0, ay_s3}));
		d2_s4          <= dpa_pkg::sq_s(d_s3);
		s2_s4          <= dpa_pkg::sq_s(s_s3);
		sum2_s4        <= dpa_pkg::sq_s(sum_s3);
		r12_s4         <= dpa_pkg::sq_u(r1_s3);
		ro2_s4         <= dpa_pkg::sq_u(ro_s3);
		axc_gt_hole_s4 <= CMP_W'(axc_s3) > CMP_W'(HOLE);
		lf_s4          <= lf_s3;
	end

	// ---------------- stage 5: squared radius compares
	// the shifted radius equals the plain radius when no shift applies
	logic        [SQ_W-1:0]    rs2_c, r2_c;

	assign rs2_c = SQ_W'(xc2_s4) + SQ_W'(y2_s4);
	assign r2_c  = SQ_W'(x2_s4) + SQ_W'(y2_s4);

	logic                      v_s5;
	dpa_pkg::det_t             det_s5;
	logic                      bad_s5;
	logic                      inner_ok_s5, outer_ok_s5, view2_ok_s5, oct_ok_s5;
	logic                      axc_gt_hole_s5;
	dpa_pkg::lin_flags_t       lf_s5;

	always_ff @(posedge clk) begin
		det_s5         <= det_s4;
		bad_s5         <= bad_s4;
		inner_ok_s5    <= rs2_c > SQ_W'(r12_s4);
		outer_ok_s5    <= r2_c < SQ_W'(ro2_s4);
		// 45 degree view of the beam hole, sqrt(2) folded into the bound
		view2_ok_s5    <= (SQ_W'(d2_s4) > dpa_pkg::HOLE_SQ_X2) ||
			(SQ_W'(s2_s4) > dpa_pkg::HOLE_SQ_X2);
		// octagon cut edges
		oct_ok_s5      <= SQ_W'(sum2_s4) < (SQ_W'(ro2_s4) << 1);
		axc_gt_hole_s5 <= axc_gt_hole_s4;
		lf_s5          <= lf_s4;
	end

	// ---------------- stage 6: verdict per detector
	logic acc_c;

	always_comb begin
		acc_c = 1'b1;
		case (det_s5)
			dpa_pkg::DET_STRAW: begin
				acc_c = !bad_s5 && (axc_gt_hole_s5 || lf_s5.ay_gt_hole) &&
					view2_ok_s5 && inner_ok_s5 && outer_ok_s5;
			end
			dpa_pkg::DET_RICH: begin
				acc_c = inner_ok_s5;
			end
			dpa_pkg::DET_CHOD, dpa_pkg::DET_NEWCHOD, dpa_pkg::DET_IRC: begin
				acc_c = inner_ok_s5 && outer_ok_s5;
			end
			dpa_pkg::DET_LAV: begin
				acc_c = !bad_s5 && outer_ok_s5;
			end
			dpa_pkg::DET_LKR: begin
				acc_c = inner_ok_s5 && lf_s5.ax_lt_ro && lf_s5.ay_lt_ro && oct_ok_s5;
			end
			dpa_pkg::DET_MUV1, dpa_pkg::DET_MUV2: begin
				acc_c = inner_ok_s5 && lf_s5.ax_lt_ro && lf_s5.ay_lt_ro;
			end
			dpa_pkg::DET_MUV3: begin
				acc_c = inner_ok_s5 && lf_s5.ax_lt_ro_wide && lf_s5.ay_lt_ro;
			end
			dpa_pkg::DET_SAC: begin
				acc_c = lf_s5.ax_lt_r1 && lf_s5.ay_lt_r1;
			end
			default: begin
				// unknown detectors accept
				acc_c = 1'b1;
			end
		endcase
	end

	logic acc_q, bad_q, done_q;

	always_ff @(posedge clk) begin
		acc_q <= acc_c;
		bad_q <= bad_s5;
	end

	// valid bits travel alongside the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= take;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	assign done        = done_q;
	assign accepted    = acc_q;
	assign bad_station = bad_q;

endmodule

FILE: src/dpa_checker.sv
// port-level checker of the point acceptance unit and its bind
`include "assert_macros.svh"

module dpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [dpa_pkg::DET_W-1:0]     detector_code,
	input logic                          done,
	input logic                          accepted,
	input logic                          bad_station
);

	// every start beat yields a verdict after the fixed latency
	`DPA_ASSERT_IMPLY(a_latency, clk, arst_n, start && !busy, ##(dpa_pkg::LATENCY) done, "result missing after start beat")

	// no verdict without a start beat
	`DPA_ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, $past(start && !busy, dpa_pkg::LATENCY), "result without start beat")

	// a bad station always rejects
	`DPA_ASSERT_NEVER(a_bad_rejects, clk, arst_n, done && bad_station && accepted, "bad station accepted")

	// only straw chambers and lav stations can flag a station
	`DPA_ASSERT_IMPLY(a_bad_source, clk, arst_n, done && bad_station, ($past(detector_code, dpa_pkg::LATENCY) == dpa_pkg::DET_STRAW) || ($past(detector_code, dpa_pkg::LATENCY) == dpa_pkg::DET_LAV), "bad station on wrong detector")

endmodule

bind detector_point_acceptance_unit dpa_checker u_dpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.detector_code (detector_code),
	.done          (done),
	.accepted      (accepted),
	.bad_station   (bad_station)
);

FILE: test/detector_point_acceptance_unit_test.sv
// self-checking testbench of the detector point acceptance unit
`timescale 1ns / 1ps

module detector_point_acceptance_unit_test;

	localparam int POS_W   = dpa_pkg::POS_W;
	localparam int DET_W   = dpa_pkg::DET_W;
	localparam int ST_W    = dpa_pkg::ST_W;
	localparam int LIMIT_W = dpa_pkg::LIMIT_W;

	// run limit in clock cycles, far above the slowest correct run
	localparam int CYCLE_LIMIT = 200000;
	// items per random phase
	localparam int PHASE_ITEMS = 183;

	// highest detector code the field can carry, beyond the named ones
	localparam logic [DET_W-1:0] DET_CODE_MAX = '1;

	// acceptance bounds in tenths of a mm
	localparam longint HOLE_T        = 638;
	localparam longint STRAW_OUT_T   = 10000;
	localparam longint RICH_SHIFT_T  = 340;
	localparam longint RICH_IN_T     = 1000;
	localparam longint CHOD_IN_T     = 1300;
	localparam longint CHOD_OUT_T    = 11000;
	localparam longint NEWCHOD_IN_T  = 1400;
	localparam longint NEWCHOD_OUT_T = 10700;
	localparam longint IRC_IN_T      = 600;
	localparam longint IRC_OUT_T     = 1450;
	localparam longint LKR_IN_T      = 1500;
	localparam longint LKR_OUT_T     = 11300;
	localparam longint MUV_IN_T      = 1300;
	localparam longint MUV_OUT_T     = 11000;
	localparam longint MUV3_IN_T     = 1030;
	localparam longint MUV3_OUT_T    = 13200;
	localparam longint MUV3_GAP_T    = 4;
	localparam longint SAC_HALF_T    = 1000;

	// straw chamber beam hole centres and lav radii, tenths of a mm
	localparam longint HOLE_CENTRE_T [8] = '{1012, 1144, 924, 528, 528, 528, 528, 528};
	localparam longint LAV_RADIUS_T [16] = '{
		5365, 5365, 5365, 5365, 5365, 7675, 7675, 7675,
		9800, 9800, 9800, 10700, 10700, 10700, 10700, 10700};

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [DET_W-1:0]        det;
		logic [ST_W-1:0]         st;
		logic [LIMIT_W-1:0]      lim_in;
		logic [LIMIT_W-1:0]      lim_out;
		int                      idle_pct;  // chance per cycle that the sender holds back
		bit                      drain;     // hold this beat until all verdicts are back
	} hit_t;

	typedef struct packed {
		logic acc;
		logic bad;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, known from time zero
	logic                    start = 1'b0;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic [DET_W-1:0]        detector_code = '0;
	logic [ST_W-1:0]         station_number = '0;
	logic [LIMIT_W-1:0]      inner_limit = '0;
	logic [LIMIT_W-1:0]      outer_limit = '0;

	logic busy;
	logic done;
	logic accepted;
	logic bad_station;

	hit_t     hit_q[$];      // hits still to be given to the block
	verdict_t verdict_q[$];  // predicted verdicts, oldest first

	int n_issued   = 0;  // beats taken, counted by the driver
	int n_verdicts = 0;  // verdicts checked, counted by the monitor
	int n_mismatch = 0;
	int n_cycles   = 0;

	detector_point_acceptance_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.detector_code  (detector_code),
		.station_number (station_number),
		.inner_limit    (inner_limit),
		.outer_limit    (outer_limit),
		.done           (done),
		.accepted       (accepted),
		.bad_station    (bad_station)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// acceptance predictor, exact integer arithmetic on coordinates x10
	// ---------------------------------------------------------------

	// tenths of a mm into the scaled coordinate format
	function automatic longint scaled(input longint t);
		return t * (longint'(1) << dpa_pkg::COORD_FRAC_BITS);
	endfunction

	// user limit times ten, or the built-in bound when the user gives zero
	function automatic longint limit_or(input logic [LIMIT_W-1:0] u, input longint dflt_t);
		return (u != '0) ? longint'(u) * 10 : scaled(dflt_t);
	endfunction

	function automatic logic in_ring(input longint r2, input longint r1, input longint ro);
		return (r2 > r1 * r1) && (r2 < ro * ro);
	endfunction

	function automatic verdict_t judge_point(input hit_t h);
		longint   x, y, ax, ay, r2;
		longint   xs, dm, sm, hh, r1, ro, sum, xc;
		logic     view1, view2;
		verdict_t v;
		x  = longint'(h.x) * 10;
		y  = longint'(h.y) * 10;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		r2 = x * x + y * y;
		v  = '{acc: 1'b1, bad: 1'b0};
		case (h.det)
			dpa_pkg::DET_STRAW: begin
				if (h.st >= dpa_pkg::STRAW_CHAMBERS) begin
					v = '{acc: 1'b0, bad: 1'b1};
				end else begin
					// square hole in the x/y view and in the 45 degree view
					hh = scaled(HOLE_T);
					xs = x - scaled(HOLE_CENTRE_T[h.st[2:0]]);
					dm = xs - y;
					sm = xs + y;
					view1 = ((xs < 0 ? -xs : xs) > hh) || (ay > hh);
					view2 = (dm * dm > 2 * hh * hh) || (sm * sm > 2 * hh * hh);
					r1 = limit_or(h.lim_in, HOLE_T);
					ro = limit_or(h.lim_out, STRAW_OUT_T);
					v.acc = view1 && view2 && (xs * xs + y * y > r1 * r1) && (r2 < ro * ro);
				end
			end
			dpa_pkg::DET_RICH: begin
				// hole centred off axis, no outer bound
				xc = x - scaled(RICH_SHIFT_T);
				r1 = limit_or(h.lim_in, RICH_IN_T);
				v.acc = xc * xc + y * y > r1 * r1;
			end
			dpa_pkg::DET_CHOD: begin
				v.acc = in_ring(r2, limit_or(h.lim_in, CHOD_IN_T),
					limit_or(h.lim_out, CHOD_OUT_T));
			end
			dpa_pkg::DET_NEWCHOD: begin
				v.acc = in_ring(r2, limit_or(h.lim_in, NEWCHOD_IN_T),
					limit_or(h.lim_out, NEWCHOD_OUT_T));
			end
			dpa_pkg::DET_LAV: begin
				if (h.st >= dpa_pkg::LAV_STATIONS) begin
					v = '{acc: 1'b0, bad: 1'b1};
				end else begin
					ro = limit_or(h.lim_out, LAV_RADIUS_T[h.st]);
					v.acc = r2 < ro * ro;
				end
			end
			dpa_pkg::DET_IRC: begin
				v.acc = in_ring(r2, limit_or(h.lim_in, IRC_IN_T),
					limit_or(h.lim_out, IRC_OUT_T));
			end
			dpa_pkg::DET_LKR: begin
				// octagon: square cut plus the diagonal cut at sqrt(2) times the half-side
				r1  = limit_or(h.lim_in, LKR_IN_T);
				ro  = limit_or(h.lim_out, LKR_OUT_T);
				sum = ax + ay;
				v.acc = (r2 > r1 * r1) && (ax < ro) && (ay < ro) && (sum * sum < 2 * ro * ro);
			end
			dpa_pkg::DET_MUV1, dpa_pkg::DET_MUV2: begin
				r1 = limit_or(h.lim_in, MUV_IN_T);
				ro = limit_or(h.lim_out, MUV_OUT_T);
				v.acc = (r2 > r1 * r1) && (ax < ro) && (ay < ro);
			end
			dpa_pkg::DET_MUV3: begin
				// x half-side widened by half the central gap
				r1 = limit_or(h.lim_in, MUV3_IN_T);
				ro = limit_or(h.lim_out, MUV3_OUT_T);
				v.acc = (r2 > r1 * r1) && (ax < ro + scaled(MUV3_GAP_T)) && (ay < ro);
			end
			dpa_pkg::DET_SAC: begin
				r1 = limit_or(h.lim_in, SAC_HALF_T);
				v.acc = (ax < r1) && (ay < r1);
			end
			default: v.acc = 1'b1;
		endcase
		return v;
	endfunction

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	task automatic push_hit(input int x, input int y, input logic [DET_W-1:0] det,
		input logic [ST_W-1:0] st, input int li, input int lo, input int idle, input bit drain);
		hit_t h;
		h.x        = POS_W'(x);
		h.y        = POS_W'(y);
		h.det      = det;
		h.st       = st;
		h.lim_in   = LIMIT_W'(li);
		h.lim_out  = LIMIT_W'(lo);
		h.idle_pct = idle;
		h.drain    = drain;
		hit_q.push_back(h);
	endtask

	// mostly inside the detector span, some near the axis, some anywhere
	function automatic int rand_coord();
		case ($urandom_range(9))
			0:       return int'($signed(POS_W'($urandom)));
			1, 2, 3: return int'($urandom_range(19200)) - 9600;
			default: return int'($urandom_range(192000)) - 96000;
		endcase
	endfunction

	// half the time the built-in bound
	function automatic int rand_limit();
		case ($urandom_range(9))
			5, 6, 7: return int'($urandom_range(96000, 1));
			8:       return int'($urandom_range(640, 1));
			9:       return int'(LIMIT_W'($urandom));
			default: return 0;
		endcase
	endfunction

	task automatic push_random(input int idle, input bit drain);
		logic [DET_W-1:0] det;
		logic [ST_W-1:0]  st;
		det = ($urandom_range(9) != 0) ? DET_W'($urandom_range(dpa_pkg::DET_SAC)) :
			DET_W'($urandom_range(DET_CODE_MAX, dpa_pkg::DET_OTHER));
		st = ST_W'($urandom);
		// stations mostly in range, now and then out of range
		if (det == dpa_pkg::DET_STRAW && $urandom_range(6) != 0)
			st = ST_W'($urandom_range(dpa_pkg::STRAW_CHAMBERS - 1));
		if (det == dpa_pkg::DET_LAV && $urandom_range(6) != 0)
			st = ST_W'($urandom_range(dpa_pkg::LAV_STATIONS - 1));
		push_hit(rand_coord(), rand_coord(), det, st, rand_limit(), rand_limit(), idle, drain);
	endtask

	// ---------------------------------------------------------------
	// driver: one hit per start beat, random gaps per phase
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : driver
		hit_t h;
		logic took;
		if (!arst_n) begin
			start          <= 1'b0;
			pos_x          <= '0;
			pos_y          <= '0;
			detector_code  <= '0;
			station_number <= '0;
			inner_limit    <= '0;
			outer_limit    <= '0;
			n_issued       <= 0;
		end else begin
			took = start && !busy;
			if (took)
				n_issued <= n_issued + 1;
			// a new beat may be set up once the current one is taken or none is up
			if (!start || took) begin
				if (hit_q.size() == 0) begin
					start <= 1'b0;
				end else if (hit_q[0].drain && n_verdicts != n_issued + (took ? 1 : 0)) begin
					// pause until every verdict so far has come back
					start <= 1'b0;
				end else if ($urandom_range(99) < hit_q[0].idle_pct) begin
					start <= 1'b0;
				end else begin
					h = hit_q.pop_front();
					pos_x          <= h.x;
					pos_y          <= h.y;
					detector_code  <= h.det;
					station_number <= h.st;
					inner_limit    <= h.lim_in;
					outer_limit    <= h.lim_out;
					start          <= 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: predicts on each taken beat, checks each done strobe
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		hit_t     h;
		verdict_t want;
		if (arst_n) begin
			// check first, so a strobe with nothing waiting is never matched
			// against the beat taken on the same edge
			if (done) begin
				if (verdict_q.size() == 0) begin
					$error("verdict with no prediction waiting: accepted %0b bad_station %0b",
						accepted, bad_station);
					n_mismatch++;
				end else begin
					want = verdict_q.pop_front();
					if (accepted !== want.acc) begin
						$error("accepted: expected %0b, actual %0b", want.acc, accepted);
						n_mismatch++;
					end
					if (bad_station !== want.bad) begin
						$error("bad_station: expected %0b, actual %0b", want.bad, bad_station);
						n_mismatch++;
					end
					n_verdicts <= n_verdicts + 1;
				end
			end
			if (start && !busy) begin
				h.x       = pos_x;
				h.y       = pos_y;
				h.det     = detector_code;
				h.st      = station_number;
				h.lim_in  = inner_limit;
				h.lim_out = outer_limit;
				verdict_q.push_back(judge_point(h));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequence: directed hits, random phases, reset, drain, verdict
	// ---------------------------------------------------------------
	initial begin : sequencer
		int idle_pct [3];
		idle_pct = '{0, 49, 8};

		// directed part, coordinates in mm times 64, no gaps
		push_hit(19200, 0, dpa_pkg::DET_STRAW, 0, 0, 0, 0, 0);
		push_hit(-524288, 524287, dpa_pkg::DET_STRAW, 3, 0, 0, 0, 0);
		push_hit(19200, 12800, dpa_pkg::DET_STRAW, 4, 0, 0, 0, 0);      // bad straw chamber
		push_hit(0, 0, dpa_pkg::DET_STRAW, 15, 524287, 524287, 0, 0);   // bad straw chamber
		push_hit(3200, -3200, dpa_pkg::DET_STRAW, 1, 524287, 524287, 0, 0);
		push_hit(0, 0, dpa_pkg::DET_RICH, 0, 0, 0, 0, 0);
		push_hit(12800, 0, dpa_pkg::DET_RICH, 0, 0, 524287, 0, 0);      // outer limit unused
		push_hit(32000, 0, dpa_pkg::DET_CHOD, 0, 0, 0, 0, 0);
		push_hit(0, -32000, dpa_pkg::DET_NEWCHOD, 0, 6400, 64000, 0, 0);
		push_hit(32000, 0, dpa_pkg::DET_LAV, 0, 524287, 0, 0, 0);       // inner limit unused
		push_hit(64000, 0, dpa_pkg::DET_LAV, 11, 0, 0, 0, 0);
		push_hit(0, 0, dpa_pkg::DET_LAV, 12, 0, 0, 0, 0);               // bad lav station
		push_hit(0, 0, dpa_pkg::DET_LAV, 15, 524287, 524287, 0, 0);     // bad lav station
		push_hit(6400, 0, dpa_pkg::DET_IRC, 0, 0, 0, 0, 0);
		push_hit(51200, 51200, dpa_pkg::DET_LKR, 0, 0, 0, 0, 0);        // just past the diagonal cut
		push_hit(64000, 0, dpa_pkg::DET_LKR, 0, 0, 0, 0, 0);
		push_hit(12800, 64000, dpa_pkg::DET_MUV1, 0, 0, 0, 0, 0);
		push_hit(-70336, 0, dpa_pkg::DET_MUV2, 9, 0, 0, 0, 0);
		push_hit(84493, 0, dpa_pkg::DET_MUV3, 0, 0, 0, 0, 0);           // inside the widened x edge
		push_hit(6336, -6336, dpa_pkg::DET_SAC, 0, 0, 524287, 0, 0);    // outer limit unused
		push_hit(0, 0, dpa_pkg::DET_SAC, 0, 1, 0, 0, 0);
		push_hit(524287, -524288, dpa_pkg::DET_OTHER, 0, 0, 0, 0, 0);
		push_hit(-524288, -524288, DET_CODE_MAX, 15, 524287, 524287, 0, 0);
		push_hit(0, 0, dpa_pkg::DET_MUV1, 0, 524287, 524287, 0, 0);

		// random phases, each opening with a full drain, some drains inside
		foreach (idle_pct[p]) begin
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_random(idle_pct[p], (n == 0) || ($urandom_range(59) == 0));
		end

		// hold reset, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every hit to be taken and every verdict to come back
		while (hit_q.size() != 0 || start || verdict_q.size() != 0)
			@(negedge clk);
		repeat (dpa_pkg::LATENCY + 4) @(negedge clk);

		if (n_mismatch == 0 && verdict_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
